FILE: sv/esc_pkg.sv
`timescale 1ns / 1ps

package esc_pkg;

   localparam int BYTE_W  = 8;
   localparam int LIMIT_W = 16;

   localparam logic [LIMIT_W-1:0] OUT_LIMIT_RESET = 16'd255;

   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              in_last;
   } item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              has_byte;
      logic              done_res;
   } result_type;

endpackage

FILE: sv/esc_in_stage.sv
`timescale 1ns / 1ps

module esc_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  esc_pkg::item_type req_item,
   output logic              item_valid,
   output esc_pkg::item_type item,
   input  logic              advance
);
   import esc_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   // The stage takes a new beat when empty or when its current beat moves on.
   assign req_ready = !valid_ff || advance;
   assign valid_in  = req_valid || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

FILE: sv/esc_decode.sv
`timescale 1ns / 1ps

module esc_decode (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [esc_pkg::LIMIT_W-1:0]  csr_wr_data,
   input  logic                         fire,
   input  esc_pkg::item_type            item,
   output logic                         emit,
   output esc_pkg::result_type          result
);
   import esc_pkg::*;

   typedef enum logic [7:0] {
      MODE_NORMAL  = 8'b0000_0001,
      MODE_CARET   = 8'b0000_0010,
      MODE_BSLASH  = 8'b0000_0100,
      MODE_HEX1    = 8'b0000_1000,
      MODE_HEX2    = 8'b0001_0000,
      MODE_OCT1    = 8'b0010_0000,
      MODE_OCT2    = 8'b0100_0000,
      MODE_STOPPED = 8'b1000_0000
   } mode_type;

   localparam logic [BYTE_W-1:0] CHR_NUL    = 8'h00;
   localparam logic [BYTE_W-1:0] CHR_BSLASH = 8'h5C;
   localparam logic [BYTE_W-1:0] CHR_CARET  = 8'h5E;
   localparam logic [BYTE_W-1:0] CHR_X      = 8'h78;
   localparam logic [BYTE_W-1:0] CHR_S      = 8'h73;
   localparam logic [BYTE_W-1:0] CHR_E      = 8'h65;
   localparam logic [BYTE_W-1:0] CHR_B      = 8'h62;
   localparam logic [BYTE_W-1:0] CHR_N      = 8'h6E;
   localparam logic [BYTE_W-1:0] CHR_R      = 8'h72;
   localparam logic [BYTE_W-1:0] CHR_T      = 8'h74;
   localparam logic [BYTE_W-1:0] CHR_SPACE  = 8'h20;
   localparam logic [BYTE_W-1:0] CHR_ESC    = 8'h1B;
   localparam logic [BYTE_W-1:0] CHR_BS     = 8'h08;
   localparam logic [BYTE_W-1:0] CHR_LF     = 8'h0A;
   localparam logic [BYTE_W-1:0] CHR_CR     = 8'h0D;
   localparam logic [BYTE_W-1:0] CHR_TAB    = 8'h09;
   localparam logic [BYTE_W-1:0] CTRL_MASK  = 8'h1F;

   function automatic logic [3:0] hex_val(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] t;
      t = 8'h00;
      case (b) inside
         [8'h30:8'h39]: t = b - 8'h30;
         [8'h61:8'h66]: t = b - 8'h57;
         [8'h41:8'h46]: t = b - 8'h37;
         default:       t = 8'h00;
      endcase
      return t[3:0];
   endfunction

   function automatic logic [3:0] dig_val(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] t;
      t = 8'h00;
      case (b) inside
         [8'h30:8'h39]: t = b - 8'h30;
         default:       t = 8'h00;
      endcase
      return t[3:0];
   endfunction

   mode_type           mode_ff, mode_in, mode_eff;
   logic [BYTE_W-1:0]  partial_ff, partial_in;
   logic [LIMIT_W-1:0] count_ff, count_in;
   logic [LIMIT_W-1:0] limit_ff;
   logic               below;
   logic               have_raw, have;
   logic [BYTE_W-1:0]  ob;
   logic [BYTE_W-1:0]  b;

   assign b        = item.in_byte;
   assign below    = count_ff < limit_ff;
   assign mode_eff = (b == CHR_NUL) ? MODE_STOPPED : mode_ff;

   always_comb begin
      mode_in    = mode_eff;
      partial_in = partial_ff;
      have_raw   = 1'b0;
      ob         = 8'h00;
      case (mode_eff)
         MODE_NORMAL: begin
            if (!below) begin
               mode_in = MODE_STOPPED;
            end else if (b == CHR_BSLASH) begin
               mode_in = MODE_BSLASH;
            end else if (b == CHR_CARET) begin
               mode_in = MODE_CARET;
            end else begin
               have_raw = 1'b1;
               ob       = b;
            end
         end
         MODE_CARET: begin
            have_raw = 1'b1;
            ob       = b & CTRL_MASK;
            mode_in  = MODE_NORMAL;
         end
         MODE_BSLASH: begin
            mode_in = MODE_NORMAL;
            case (b) inside
               CHR_X: mode_in = MODE_HEX1;
               [8'h30:8'h33]: begin
                  partial_in = {b[1:0], 6'b000000};
                  mode_in    = MODE_OCT1;
               end
               CHR_BSLASH: begin have_raw = 1'b1; ob = CHR_BSLASH; end
               CHR_CARET:  begin have_raw = 1'b1; ob = CHR_CARET;  end
               CHR_S:      begin have_raw = 1'b1; ob = CHR_SPACE;  end
               CHR_E:      begin have_raw = 1'b1; ob = CHR_ESC;    end
               CHR_B:      begin have_raw = 1'b1; ob = CHR_BS;     end
               CHR_N:      begin have_raw = 1'b1; ob = CHR_LF;     end
               CHR_R:      begin have_raw = 1'b1; ob = CHR_CR;     end
               CHR_T:      begin have_raw = 1'b1; ob = CHR_TAB;    end
               default:    mode_in = MODE_NORMAL;
            endcase
         end
         MODE_HEX1: begin
            partial_in = {4'h0, hex_val(b)};
            mode_in    = MODE_HEX2;
         end
         MODE_HEX2: begin
            have_raw = 1'b1;
            ob       = {partial_ff[3:0], hex_val(b)};
            mode_in  = MODE_NORMAL;
         end
         MODE_OCT1: begin
            partial_in = partial_ff + {1'b0, dig_val(b), 3'b000};
            mode_in    = MODE_OCT2;
         end
         MODE_OCT2: begin
            have_raw = 1'b1;
            ob       = partial_ff + {4'h0, dig_val(b)};
            mode_in  = MODE_NORMAL;
         end
         default: mode_in = MODE_STOPPED;
      endcase
   end

   assign have     = have_raw && below;
   assign count_in = have ? count_ff + 16'd1 : count_ff;

   assign emit            = have || item.in_last;
   assign result.out_byte = have ? ob : 8'h00;
   assign result.has_byte = have;
   assign result.done_res = item.in_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_NORMAL;
         partial_ff <= 8'h00;
         count_ff   <= 16'd0;
      end else if (fire) begin
         if (item.in_last) begin
            mode_ff    <= MODE_NORMAL;
            partial_ff <= 8'h00;
            count_ff   <= 16'd0;
         end else begin
            mode_ff    <= mode_in;
            partial_ff <= partial_in;
            count_ff   <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= OUT_LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      fire && item.in_last |=> count_ff == 16'd0 && mode_ff == MODE_NORMAL)
      else $error("string state not cleared after last beat");

   a_count_holds: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(count_ff))
      else $error("byte count moved without a beat");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      fire && !item.in_last |=> count_ff == $past(count_ff) + {15'd0, $past(have)})
      else $error("byte count out of step with decoded bytes");

endmodule

FILE: sv/esc_out_stage.sv
`timescale 1ns / 1ps

module esc_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                emit,
   input  esc_pkg::result_type result,
   output logic                space,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output esc_pkg::result_type rsp_result
);
   import esc_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   assign space    = !valid_ff || rsp_ready;
   assign valid_in = advance ? emit : (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

FILE: sv/escape_notation_decoder.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// req_      in         req_valid / req_ready   req_in_byte, req_in_last
// rsp_      out        rsp_valid / rsp_ready   rsp_out_byte, rsp_has_byte, rsp_done_res
// csr_      in         csr_wr_en               csr_wr_data (out_limit)
//
// Each beat passes from acceptance into the input register, then through the decode logic
// into the result register. One beat is accepted per cycle unless the result stalls;
// the mode, partial value and byte count update as each beat leaves the input register.
// Reset is synchronous and returns the decoder to normal mode with out_limit at 255.
// A stalled result holds the result register, which in turn holds the input register.

module escape_notation_decoder (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [7:0]                  req_in_byte,
   input  logic                        req_in_last,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [7:0]                  rsp_out_byte,
   output logic                        rsp_has_byte,
   output logic                        rsp_done_res,
   input  logic                        csr_wr_en,
   input  logic [esc_pkg::LIMIT_W-1:0] csr_wr_data
);
   import esc_pkg::*;

   item_type   req_item;
   item_type   item;
   logic       item_valid;
   logic       advance;
   logic       space;
   logic       emit;
   result_type result;
   result_type rsp_result;

   assign req_item.in_byte = req_in_byte;
   assign req_item.in_last = req_in_last;
   assign advance          = item_valid && space;

   esc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .item_valid (item_valid),
      .item       (item),
      .advance    (advance)
   );

   esc_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fire        (advance),
      .item        (item),
      .emit        (emit),
      .result      (result)
   );

   esc_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .emit       (emit),
      .result     (result),
      .space      (space),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (rsp_result)
   );

   assign rsp_out_byte = rsp_result.out_byte;
   assign rsp_has_byte = rsp_result.has_byte;
   assign rsp_done_res = rsp_result.done_res;

   a_rsp_content: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_has_byte || rsp_done_res)
      else $error("result beat carries neither a byte nor done");

   a_rsp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_byte |-> rsp_out_byte == 8'h00)
      else $error("empty result beat has a nonzero byte");

endmodule
